@@ hw/rtl/mdio_fm_pkg.sv @@
`default_nettype none

package mdio_fm_pkg;

    localparam int LEAD_ZEROS_DEF    = 16;
    localparam int PREAMBLE_ONES_DEF = 32;
    localparam int FRAME_SLOTS       = 34;

    localparam int CMD_W  = 2;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 16;
    localparam int FRAME_W = 32;
    localparam int GATH_W  = 19;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

    // driven frame lengths in slots
    localparam logic [5:0] READ_DRIVEN  = 6'd15;
    localparam logic [5:0] WRITE_DRIVEN = 6'd32;

    // leading one + start + read opcode, start + write opcode, write turnaround
    localparam logic [4:0] RD_HDR = 5'b10110;
    localparam logic [3:0] WR_HDR = 4'b0101;
    localparam logic [1:0] WR_TA  = 2'b10;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] phy_addr;
        logic [ADDR_W-1:0] reg_addr;
        logic [DATA_W-1:0] write_data;
        logic              line_in;
    } t_req;

    typedef struct packed {
        logic              line_out;
        logic              line_drive;
        logic              slot_used;
        logic              busy_res;
        logic              read_valid;
        logic [DATA_W-1:0] read_data;
    } t_rsp;

endpackage

`default_nettype wire

@@ hw/rtl/mdio_fm_if.sv @@
`default_nettype none

interface mdio_fm_req_if;
    logic                               valid;
    logic                               ready;
    logic [mdio_fm_pkg::CMD_W-1:0]      cmd;
    logic [mdio_fm_pkg::ADDR_W-1:0]     phy_addr;
    logic [mdio_fm_pkg::ADDR_W-1:0]     reg_addr;
    logic [mdio_fm_pkg::DATA_W-1:0]     write_data;
    logic                               line_in;

    modport source (output valid, cmd, phy_addr, reg_addr, write_data, line_in,
                    input ready);
    modport sink   (input valid, cmd, phy_addr, reg_addr, write_data, line_in,
                    output ready);
endinterface

interface mdio_fm_rsp_if;
    logic                               valid;
    logic                               ready;
    logic                               line_out;
    logic                               line_drive;
    logic                               slot_used;
    logic                               busy_res;
    logic                               read_valid;
    logic [mdio_fm_pkg::DATA_W-1:0]     read_data;

    modport source (output valid, line_out, line_drive, slot_used, busy_res,
                    read_valid, read_data, input ready);
    modport sink   (input valid, line_out, line_drive, slot_used, busy_res,
                    read_valid, read_data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/mdio_management_frame_master_top.sv @@
`default_nettype none
// Each result is registered in the output buffer when its request is accepted.
// Throughput: one request per cycle; a two-entry output buffer keeps input
// ready high until two results are waiting unread.
// A transaction is one start request plus LEAD_ZEROS + PREAMBLE_ONES + 34 ticks.
// Reset (synchronous, active low) returns the master to idle and empties the buffer.

module mdio_management_frame_master_top #(
    parameter int LEAD_ZEROS    = mdio_fm_pkg::LEAD_ZEROS_DEF,
    parameter int PREAMBLE_ONES = mdio_fm_pkg::PREAMBLE_ONES_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    mdio_fm_req_if.sink    i_req,
    mdio_fm_rsp_if.source  o_rsp
);
    import mdio_fm_pkg::*;

    t_req w_req;
    t_rsp w_core_rsp;
    t_rsp w_out;
    logic w_ready;
    logic w_push;

    assign w_req.cmd        = i_req.cmd;
    assign w_req.phy_addr   = i_req.phy_addr;
    assign w_req.reg_addr   = i_req.reg_addr;
    assign w_req.write_data = i_req.write_data;
    assign w_req.line_in    = i_req.line_in;

    assign i_req.ready = w_ready;
    assign w_push      = i_req.valid && w_ready;

    mdio_fm_core #(
        .LEAD_ZEROS    (LEAD_ZEROS),
        .PREAMBLE_ONES (PREAMBLE_ONES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_req   (w_req),
        .o_rsp   (w_core_rsp)
    );

    mdio_fm_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (w_ready),
        .i_data  (w_core_rsp),
        .o_valid (o_rsp.valid),
        .i_ready (o_rsp.ready),
        .o_data  (w_out)
    );

    assign o_rsp.line_out   = w_out.line_out;
    assign o_rsp.line_drive = w_out.line_drive;
    assign o_rsp.slot_used  = w_out.slot_used;
    assign o_rsp.busy_res   = w_out.busy_res;
    assign o_rsp.read_valid = w_out.read_valid;
    assign o_rsp.read_data  = w_out.read_data;

endmodule

`default_nettype wire

@@ hw/rtl/mdio_fm_core.sv @@
`default_nettype none

module mdio_fm_core #(
    parameter int LEAD_ZEROS    = mdio_fm_pkg::LEAD_ZEROS_DEF,
    parameter int PREAMBLE_ONES = mdio_fm_pkg::PREAMBLE_ONES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  mdio_fm_pkg::t_req      i_req,
    output mdio_fm_pkg::t_rsp      o_rsp
);
    import mdio_fm_pkg::*;

    localparam int TOTAL  = LEAD_ZEROS + PREAMBLE_ONES + FRAME_SLOTS;
    localparam int SLOT_W = $clog2(TOTAL + 1);

    localparam logic [SLOT_W-1:0] LEAD_END  = SLOT_W'(LEAD_ZEROS);
    localparam logic [SLOT_W-1:0] PRE_END   = SLOT_W'(LEAD_ZEROS + PREAMBLE_ONES);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TOTAL - 1);

    logic                r_active,  n_active;
    logic [SLOT_W-1:0]   r_slot,    n_slot;
    logic                r_is_read, n_is_read;
    logic [FRAME_W-1:0]  r_frame,   n_frame;
    logic [GATH_W-1:0]   r_gath,    n_gath;

    logic                w_start;
    logic                w_last;
    logic [SLOT_W-1:0]   w_f;
    logic [5:0]          w_f6;
    logic [5:0]          w_dlen;
    logic [5:0]          w_idx;
    t_rsp                w_rsp;

    assign w_start = (i_req.cmd == CMD_READ) || (i_req.cmd == CMD_WRITE);
    assign w_last  = (r_slot == LAST_SLOT);
    assign w_f     = r_slot - PRE_END;
    assign w_f6    = w_f[5:0];
    assign w_dlen  = r_is_read ? READ_DRIVEN : WRITE_DRIVEN;
    assign w_idx   = w_dlen - 6'd1 - w_f6;

    always_comb begin
        n_active  = r_active;
        n_slot    = r_slot;
        n_is_read = r_is_read;
        n_frame   = r_frame;
        n_gath    = r_gath;
        w_rsp     = '0;
        if (w_start) begin
            w_rsp.busy_res = 1'b1;
            if (!r_active) begin
                n_active  = 1'b1;
                n_slot    = '0;
                n_gath    = '0;
                n_is_read = (i_req.cmd == CMD_READ);
                if (i_req.cmd == CMD_READ) begin
                    n_frame = {17'd0, RD_HDR, i_req.phy_addr, i_req.reg_addr};
                end else begin
                    n_frame = {WR_HDR, i_req.phy_addr, i_req.reg_addr, WR_TA,
                               i_req.write_data};
                end
            end
        end else if (r_active) begin
            w_rsp.slot_used = 1'b1;
            if (r_slot < LEAD_END) begin
                w_rsp.line_drive = 1'b1;
            end else if (r_slot < PRE_END) begin
                w_rsp.line_drive = 1'b1;
                w_rsp.line_out   = 1'b1;
            end else if (w_f6 < w_dlen) begin
                w_rsp.line_drive = 1'b1;
                w_rsp.line_out   = r_frame[w_idx[4:0]];
            end else if (r_is_read) begin
                n_gath = {r_gath[GATH_W-2:0], i_req.line_in};
            end
            if (w_last) begin
                n_active = 1'b0;
                n_slot   = '0;
                if (r_is_read) begin
                    w_rsp.read_valid = 1'b1;
                    w_rsp.read_data  = n_gath[DATA_W:1];
                end
            end else begin
                n_slot = r_slot + 1'b1;
            end
            w_rsp.busy_res = n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_slot    <= '0;
            r_is_read <= 1'b0;
            r_frame   <= '0;
            r_gath    <= '0;
        end else if (i_push) begin
            r_active  <= n_active;
            r_slot    <= n_slot;
            r_is_read <= n_is_read;
            r_frame   <= n_frame;
            r_gath    <= n_gath;
        end
    end

    assign o_rsp = w_rsp;

    a_idle_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_slot == '0))
        else $error("slot counter nonzero while idle");

    a_start_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && w_start && !r_active) |=> (r_active && r_slot == '0))
        else $error("start request did not arm a transaction");

    a_last_slot_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !w_start && r_active && w_last) |=> !r_active)
        else $error("transaction ran past its last slot");

    a_read_valid_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.read_valid |-> (w_rsp.slot_used && !w_rsp.busy_res && r_is_read))
        else $error("read result outside final read slot");

endmodule

`default_nettype wire

@@ hw/rtl/mdio_fm_skid.sv @@
`default_nettype none

module mdio_fm_skid (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  mdio_fm_pkg::t_rsp      i_data,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output mdio_fm_pkg::t_rsp      o_data
);
    import mdio_fm_pkg::*;

    logic r_main_valid;
    logic r_skid_valid;
    t_rsp r_main;
    t_rsp r_skid;
    logic w_push;
    logic w_pop;

    assign o_ready = !r_skid_valid;
    assign w_push  = i_valid && !r_skid_valid;
    assign w_pop   = r_main_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_pop) begin
            // skid entry moves up; a new request can only land when skid is empty
            r_main_valid <= r_skid_valid || w_push;
            r_skid_valid <= 1'b0;
        end else if (w_push) begin
            if (!r_main_valid) begin
                r_main_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end else if (w_push) begin
            if (!r_main_valid) begin
                r_main <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

    assign o_valid = r_main_valid;
    assign o_data  = r_main;

endmodule

`default_nettype wire

@@ tb/mdio_management_frame_master_top_test.sv @@
`timescale 1ns / 1ps

module mdio_management_frame_master_top_test;
    import mdio_fm_pkg::*;

    // unused opcode; the master treats it as a plain tick
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int SLOTS_PER_FRAME = LEAD_ZEROS_DEF + PREAMBLE_ONES_DEF + FRAME_SLOTS;
    localparam int RANDOM_ITEMS    = 650;
    localparam int CYCLE_LIMIT     = 200000;

    localparam int LINE_LOW  = 0;
    localparam int LINE_HIGH = 1;
    localparam int LINE_RAND = 2;

    logic i_clk;
    logic i_rst_n;

    mdio_fm_req_if req_ch ();
    mdio_fm_rsp_if rsp_ch ();

    mdio_management_frame_master_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // master state as predicted
    bit          mdio_active;
    int unsigned slot_idx;
    bit          frame_is_read;
    logic [31:0] frame_shift;
    logic [18:0] read_shift;

    t_rsp        slot_results_due[$];
    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned requests_sent;

    // sender bursts / receiver stall pattern
    bit          tx_gaps_on;
    bit          rx_stalls_on;
    int unsigned burst_left;
    int unsigned rx_run_left;
    bit          rx_hold;

    function automatic t_rsp mdio_slot_step(t_req r);
        t_rsp        o;
        int unsigned f;
        int unsigned dlen;
        o = '0;
        if (r.cmd == CMD_READ || r.cmd == CMD_WRITE) begin
            if (!mdio_active) begin
                mdio_active   = 1'b1;
                slot_idx      = 0;
                read_shift    = '0;
                frame_is_read = (r.cmd == CMD_READ);
                if (frame_is_read)
                    frame_shift = {17'd0, RD_HDR, r.phy_addr, r.reg_addr};
                else
                    frame_shift = {WR_HDR, r.phy_addr, r.reg_addr, WR_TA, r.write_data};
            end
            o.busy_res = 1'b1;
            return o;
        end
        if (!mdio_active)
            return o;

        if (slot_idx < LEAD_ZEROS_DEF) begin
            o.line_drive = 1'b1;
        end else if (slot_idx < LEAD_ZEROS_DEF + PREAMBLE_ONES_DEF) begin
            o.line_drive = 1'b1;
            o.line_out   = 1'b1;
        end else begin
            f    = slot_idx - LEAD_ZEROS_DEF - PREAMBLE_ONES_DEF;
            dlen = frame_is_read ? READ_DRIVEN : WRITE_DRIVEN;
            if (f < dlen) begin
                o.line_drive = 1'b1;
                o.line_out   = frame_shift[dlen - 1 - f];
            end else if (frame_is_read) begin
                read_shift = {read_shift[17:0], r.line_in};
            end
        end
        o.slot_used = 1'b1;

        slot_idx++;
        if (slot_idx >= SLOTS_PER_FRAME) begin
            mdio_active = 1'b0;
            slot_idx    = 0;
            if (frame_is_read) begin
                o.read_valid = 1'b1;
                o.read_data  = read_shift[16:1];
            end
        end
        o.busy_res = mdio_active;
        return o;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // requests are predicted as they are accepted, results checked in order
    always @(posedge i_clk) begin
        t_req acc;
        t_rsp want;
        cycle_count++;
        if (!i_rst_n) begin
            mdio_active   = 1'b0;
            slot_idx      = 0;
            frame_is_read = 1'b0;
            frame_shift   = '0;
            read_shift    = '0;
            slot_results_due.delete();
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                acc.cmd        = req_ch.cmd;
                acc.phy_addr   = req_ch.phy_addr;
                acc.reg_addr   = req_ch.reg_addr;
                acc.write_data = req_ch.write_data;
                acc.line_in    = req_ch.line_in;
                slot_results_due.push_back(mdio_slot_step(acc));
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (slot_results_due.size() == 0) begin
                    $error("result with no request outstanding");
                    mismatch_count++;
                end else begin
                    want = slot_results_due.pop_front();
                    check_field("line_out",   want.line_out,   rsp_ch.line_out);
                    check_field("line_drive", want.line_drive, rsp_ch.line_drive);
                    check_field("slot_used",  want.slot_used,  rsp_ch.slot_used);
                    check_field("busy_res",   want.busy_res,   rsp_ch.busy_res);
                    check_field("read_valid", want.read_valid, rsp_ch.read_valid);
                    check_field("read_data",  want.read_data,  rsp_ch.read_data);
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge i_clk);
        $display("TEST FAILED");
        $finish;
    end

    // receiver: always ready, or alternating ready / stall runs of random length when stalls are on
    always @(negedge i_clk) begin
        if (!rx_stalls_on) begin
            rsp_ch.ready <= 1'b1;
        end else begin
            if (rx_run_left == 0) begin
                rx_hold     = !rx_hold;
                rx_run_left = rx_hold ? $urandom_range(1, 10) : $urandom_range(1, 5);
            end
            rx_run_left--;
            rsp_ch.ready <= rx_hold;
        end
    end

    task automatic send_slot_request(t_req r);
        int unsigned gap;
        if (tx_gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                req_ch.valid <= 1'b0;
            end
        end
        if (burst_left != 0)
            burst_left--;
        @(negedge i_clk);
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= r.cmd;
        req_ch.phy_addr   <= r.phy_addr;
        req_ch.reg_addr   <= r.reg_addr;
        req_ch.write_data <= r.write_data;
        req_ch.line_in    <= r.line_in;
        do
            @(posedge i_clk);
        while (!req_ch.ready);
        requests_sent++;
    endtask

    function automatic t_req random_request(logic [CMD_W-1:0] cmd);
        t_req r;
        r.cmd        = cmd;
        r.phy_addr   = ADDR_W'($urandom_range(0, 31));
        r.reg_addr   = ADDR_W'($urandom_range(0, 31));
        r.write_data = DATA_W'($urandom_range(0, 65535));
        r.line_in    = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // one start request and the full run of slot ticks; noisy frames get
    // ignored starts and spare-code ticks mixed in
    task automatic run_frame(logic [CMD_W-1:0] start_cmd, logic [ADDR_W-1:0] phy,
                             logic [ADDR_W-1:0] regn, logic [DATA_W-1:0] data,
                             int line_mode, bit noisy);
        t_req r;
        int   ticks;
        r            = random_request(start_cmd);
        r.phy_addr   = phy;
        r.reg_addr   = regn;
        r.write_data = data;
        send_slot_request(r);
        ticks = 0;
        while (ticks < SLOTS_PER_FRAME) begin
            if (noisy && $urandom_range(0, 11) == 0) begin
                send_slot_request(random_request($urandom_range(0, 1) ? CMD_READ : CMD_WRITE));
            end else begin
                r = random_request((noisy && $urandom_range(0, 7) == 0) ? CMD_SPARE : CMD_TICK);
                if (line_mode == LINE_LOW)
                    r.line_in = 1'b0;
                else if (line_mode == LINE_HIGH)
                    r.line_in = 1'b1;
                send_slot_request(r);
                ticks++;
            end
        end
    endtask

    // drop valid first so the last request is not taken a second time
    task automatic wait_for_results();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (slot_results_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_idle_commands();
        t_req r;
        r = '{cmd: CMD_TICK, phy_addr: '1, reg_addr: '1, write_data: '1, line_in: 1'b1};
        send_slot_request(r);
        r.cmd = CMD_SPARE;
        send_slot_request(r);
        r = '{cmd: CMD_SPARE, phy_addr: '0, reg_addr: '0, write_data: '0, line_in: 1'b0};
        send_slot_request(r);
        r.cmd = CMD_TICK;
        send_slot_request(r);
        wait_for_results();
    endtask

    task automatic test_write_frames();
        run_frame(CMD_WRITE, 5'd31, 5'd0, 16'hFFFF, LINE_HIGH, 1'b1);
        run_frame(CMD_WRITE, 5'd0, 5'd31, 16'h0000, LINE_LOW, 1'b0);
        wait_for_results();
    endtask

    task automatic test_read_frames();
        run_frame(CMD_READ, 5'd0, 5'd31, 16'hFFFF, LINE_HIGH, 1'b0);
        run_frame(CMD_READ, 5'd31, 5'd0, 16'h0000, LINE_LOW, 1'b1);
        // read straight after write, no idle tick in between
        run_frame(CMD_WRITE, 5'd21, 5'd10, 16'hA5A5, LINE_RAND, 1'b0);
        run_frame(CMD_READ, 5'd10, 5'd21, 16'h5A5A, LINE_RAND, 1'b0);
        wait_for_results();
    endtask

    task automatic test_random_frames();
        int unsigned goal;
        int unsigned idle_ticks;
        bit          paused;
        goal   = requests_sent + RANDOM_ITEMS;
        paused = 1'b0;
        while (requests_sent < goal) begin
            tx_gaps_on   = ($urandom_range(0, 3) != 0);
            rx_stalls_on = ($urandom_range(0, 3) != 0);
            idle_ticks   = $urandom_range(0, 2);
            repeat (idle_ticks)
                send_slot_request(random_request($urandom_range(0, 3) == 0 ? CMD_SPARE
                                                                            : CMD_TICK));
            run_frame($urandom_range(0, 1) ? CMD_READ : CMD_WRITE,
                      ADDR_W'($urandom_range(0, 31)), ADDR_W'($urandom_range(0, 31)),
                      DATA_W'($urandom_range(0, 65535)), LINE_RAND,
                      $urandom_range(0, 2) == 0);
            // hold off the sender once until the pipeline drains
            if (!paused && requests_sent > goal - RANDOM_ITEMS / 2) begin
                paused = 1'b1;
                @(negedge i_clk);
                req_ch.valid <= 1'b0;
                wait_for_results();
            end
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.cmd        = CMD_TICK;
        req_ch.phy_addr   = '0;
        req_ch.reg_addr   = '0;
        req_ch.write_data = '0;
        req_ch.line_in    = 1'b0;
        rsp_ch.ready      = 1'b0;
        tx_gaps_on        = 1'b0;
        rx_stalls_on      = 1'b0;
        burst_left        = 0;
        rx_run_left       = 0;
        rx_hold           = 1'b0;
        mismatch_count    = 0;
        cycle_count       = 0;
        requests_sent     = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_commands();
        test_write_frames();
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        test_read_frames();
        test_random_frames();

        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        wait_for_results();
        repeat (10) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
